### rtl/smad_pkg.sv
`default_nettype none

package smad_pkg;

	// Address space geometry.
	localparam int ADDR_BITS    = 24;
	localparam int SLOT_BITS    = 12;
	localparam int MAX_SEGMENTS = 16;
	localparam int GRAN_BITS    = ADDR_BITS - SLOT_BITS;
	localparam int NUM_SLOTS    = 1 << SLOT_BITS;
	localparam int IDX_W        = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

	// Field widths of one beat.
	localparam int FUNC_W  = 2;
	localparam int ADDR_W  = 32;
	localparam int SIZE_W  = 25;
	localparam int ASZ_W   = 3;
	localparam int ID_W    = 5;
	localparam int STAT_W  = 3;
	localparam int OFF_W   = 24;
	localparam int IN_DW   = 72;
	localparam int OUT_DW  = 40;

	// Derived widths.
	localparam int CNT_W  = SIZE_W - GRAN_BITS;
	localparam int REFC_W = SLOT_BITS + 1;
	localparam int SUM_W  = ((ADDR_BITS > SIZE_W) ? ADDR_BITS : SIZE_W) + 1;
	localparam logic [ADDR_W:0] SPACE_BYTES = (ADDR_W + 1)'(1) << ADDR_BITS;

	// Function codes carried in tuser.
	localparam logic [FUNC_W-1:0] FUNC_INSTALL = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_ACCESS  = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_PEEK    = 2'd2;

	// Result status codes.
	localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
	localparam logic [STAT_W-1:0] STAT_MISALIGN = 3'd1;
	localparam logic [STAT_W-1:0] STAT_OVERLAP  = 3'd2;
	localparam logic [STAT_W-1:0] STAT_NOSPACE  = 3'd3;
	localparam logic [STAT_W-1:0] STAT_FAULT    = 3'd4;

	// Slot memory operation for the current cycle.
	typedef enum logic [2:0] {
		MEM_NONE,
		MEM_CLEAR,
		MEM_READ_SLOT,
		MEM_FILL,
		MEM_READ_ADDR
	} mem_op_t;

	// Which result the datapath captures into its pending register.
	typedef enum logic [3:0] {
		RES_NONE,
		RES_MISALIGN,
		RES_NOSPACE,
		RES_OVERLAP,
		RES_INSTALLED,
		RES_FAULT,
		RES_ACCESS,
		RES_PEEK,
		RES_ZERO
	} res_sel_t;

	typedef struct packed {
		logic     load;
		logic     cnt_clr;
		logic     cnt_inc;
		mem_op_t  mem_op;
		logic     commit;
		res_sel_t res;
		logic     push;
	} smad_cmd_t;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic              misaligned;
		logic              no_space;
		logic              size_zero;
		logic              addr_out;
		logic              scan_hit;
		logic              cnt_last;
		logic              clr_last;
		logic              out_free;
	} smad_stat_t;

endpackage

`default_nettype wire

### rtl/smad_ctrl.sv
`default_nettype none

module smad_ctrl (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  in_valid,
	output logic                 in_ready,
	input  smad_pkg::smad_stat_t stat,
	output smad_pkg::smad_cmd_t  cmd
);
	import smad_pkg::*;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_DECODE,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_FILL,
		ST_LOOKUP,
		ST_PEEK,
		ST_RESP
	} state_t;

	state_t state_q;
	state_t state_d;

	assign in_ready = (state_q == ST_IDLE);

	// Command decode and next state.
	always_comb begin
		state_d     = state_q;
		cmd.load    = 1'b0;
		cmd.cnt_clr = 1'b0;
		cmd.cnt_inc = 1'b0;
		cmd.mem_op  = MEM_NONE;
		cmd.commit  = 1'b0;
		cmd.res     = RES_NONE;
		cmd.push    = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.mem_op  = MEM_CLEAR;
				cmd.cnt_inc = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load    = 1'b1;
					cmd.cnt_clr = 1'b1;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (stat.func)
					FUNC_INSTALL: begin
						if (stat.misaligned) begin
							cmd.res = RES_MISALIGN;
							state_d = ST_RESP;
						end else if (stat.no_space) begin
							cmd.res = RES_NOSPACE;
							state_d = ST_RESP;
						end else if (stat.size_zero) begin
							cmd.commit = 1'b1;
							cmd.res    = RES_INSTALLED;
							state_d    = ST_RESP;
						end else begin
							state_d = ST_SCAN_RD;
						end
					end
					FUNC_ACCESS: begin
						if (stat.addr_out) begin
							cmd.res = RES_FAULT;
							state_d = ST_RESP;
						end else begin
							cmd.mem_op = MEM_READ_ADDR;
							state_d    = ST_LOOKUP;
						end
					end
					FUNC_PEEK: begin
						cmd.mem_op = MEM_READ_ADDR;
						state_d    = ST_PEEK;
					end
					default: begin
						cmd.res = RES_ZERO;
						state_d = ST_RESP;
					end
				endcase
			end
			ST_SCAN_RD: begin
				cmd.mem_op = MEM_READ_SLOT;
				state_d    = ST_SCAN_CHK;
			end
			ST_SCAN_CHK: begin
				if (stat.scan_hit) begin
					cmd.res = RES_OVERLAP;
					state_d = ST_RESP;
				end else if (stat.cnt_last) begin
					cmd.cnt_clr = 1'b1;
					state_d     = ST_FILL;
				end else begin
					cmd.cnt_inc = 1'b1;
					state_d     = ST_SCAN_RD;
				end
			end
			ST_FILL: begin
				cmd.mem_op = MEM_FILL;
				if (stat.cnt_last) begin
					cmd.commit = 1'b1;
					cmd.res    = RES_INSTALLED;
					state_d    = ST_RESP;
				end else begin
					cmd.cnt_inc = 1'b1;
				end
			end
			ST_LOOKUP: begin
				cmd.res = RES_ACCESS;
				state_d = ST_RESP;
			end
			ST_PEEK: begin
				cmd.res = RES_PEEK;
				state_d = ST_RESP;
			end
			ST_RESP: begin
				if (stat.out_free) begin
					cmd.push = 1'b1;
					state_d  = ST_IDLE;
				end
			end
		endcase
	end

	// State register; reset starts the slot clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

### rtl/smad_dp.sv
`default_nettype none

module smad_dp (
	input  wire                           clk,
	input  wire                           arst_n,
	input  smad_pkg::smad_cmd_t           cmd,
	input  wire [smad_pkg::IN_DW-1:0]     in_data,
	input  wire [smad_pkg::FUNC_W-1:0]    in_func,
	input  wire                           out_ready,
	output logic                          out_valid,
	output logic [smad_pkg::OUT_DW-1:0]   out_data,
	output smad_pkg::smad_stat_t          stat
);
	import smad_pkg::*;

	// Captured item.
	logic [FUNC_W-1:0] func_q;
	logic [ADDR_W-1:0] addr_q;
	logic [SIZE_W-1:0] size_q;
	logic [ASZ_W-1:0]  asz_q;
	logic [ID_W-1:0]   id_q;
	logic              ra_q;

	// Slot walk counter, also used by the clearing pass.
	logic [SLOT_BITS-1:0] cnt_q;

	// Slot map memory and its registered read data.
	logic [ID_W-1:0] slot_mem [NUM_SLOTS];
	logic [ID_W-1:0] rd_q;

	// Segment descriptor table. The base keeps one bit above the space, so that a
	// zero-size segment placed right at the end of the space is held exactly.
	logic [ADDR_BITS:0]   base_q [MAX_SEGMENTS];
	logic [SIZE_W-1:0]    len_q  [MAX_SEGMENTS];
	logic                 rdact_q [MAX_SEGMENTS];
	logic [REFC_W-1:0]    refc_q [MAX_SEGMENTS];

	// Pending result and output register.
	logic [STAT_W-1:0] pend_stat_q;
	logic [ID_W-1:0]   pend_hit_q;
	logic [OFF_W-1:0]  pend_off_q;
	logic              pend_blk_q;
	logic              out_valid_q;
	logic [OUT_DW-1:0] out_data_q;

	logic [CNT_W-1:0]     slot_count;
	logic [SLOT_BITS-1:0] first_slot;
	logic [SLOT_BITS-1:0] addr_slot;
	logic [SLOT_BITS-1:0] mem_addr;
	logic                 mem_we;
	logic [ID_W-1:0]      mem_wdata;
	logic                 mem_re;
	logic [ADDR_W:0]      end_sum;
	logic [IDX_W-1:0]     inst_idx;
	logic [IDX_W-1:0]     hit_idx;
	logic                 hit_valid;
	logic [ADDR_BITS:0]   hit_base;
	logic [SUM_W-1:0]     acc_end;
	logic [SUM_W-1:0]     seg_end;
	logic                 acc_fault;
	logic [OFF_W-1:0]     acc_off;

	// Install geometry and checks.
	assign slot_count = size_q[SIZE_W-1:GRAN_BITS];
	assign first_slot = addr_q[ADDR_BITS-1:GRAN_BITS];
	assign addr_slot  = addr_q[ADDR_BITS-1:GRAN_BITS];
	assign end_sum    = {1'b0, addr_q} + (ADDR_W + 1)'(size_q);
	assign inst_idx   = IDX_W'(id_q - ID_W'(1));

	assign stat.func       = func_q;
	assign stat.misaligned = (|addr_q[GRAN_BITS-1:0]) || (|size_q[GRAN_BITS-1:0]);
	assign stat.no_space   = (id_q == '0) || (int'(id_q) > MAX_SEGMENTS)
		|| (end_sum > SPACE_BYTES);
	assign stat.size_zero  = (slot_count == '0);
	assign stat.addr_out   = ({1'b0, addr_q} >= SPACE_BYTES);
	assign stat.scan_hit   = (rd_q != '0);
	assign stat.cnt_last   = (CNT_W'(cnt_q) == slot_count - CNT_W'(1));
	assign stat.clr_last   = &cnt_q;
	assign stat.out_free   = !out_valid_q || out_ready;

	// Slot memory port selection.
	always_comb begin
		mem_addr  = first_slot + cnt_q;
		mem_we    = 1'b0;
		mem_wdata = id_q;
		mem_re    = 1'b0;
		case (cmd.mem_op)
			MEM_CLEAR: begin
				mem_addr  = cnt_q;
				mem_we    = 1'b1;
				mem_wdata = '0;
			end
			MEM_READ_SLOT: begin
				mem_re = 1'b1;
			end
			MEM_FILL: begin
				mem_we = 1'b1;
			end
			MEM_READ_ADDR: begin
				mem_addr = addr_slot;
				mem_re   = 1'b1;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			slot_mem[mem_addr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_q <= slot_mem[mem_addr];
		end
	end

	// Access check against the descriptor named by the slot.
	assign hit_valid = (rd_q != '0) && (int'(rd_q) <= MAX_SEGMENTS);
	assign hit_idx   = IDX_W'(rd_q - ID_W'(1));
	assign hit_base  = base_q[hit_idx];
	assign acc_end   = SUM_W'(addr_q[ADDR_BITS-1:0]) + SUM_W'(asz_q);
	assign seg_end   = SUM_W'(hit_base) + SUM_W'(len_q[hit_idx]);
	assign acc_fault = !hit_valid || (acc_end > seg_end);
	assign acc_off   = OFF_W'(addr_q[ADDR_BITS-1:0] - hit_base[ADDR_BITS-1:0]);

	// Item capture.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			func_q <= in_func;
			addr_q <= in_data[31:0];
			size_q <= in_data[56:32];
			asz_q  <= in_data[59:57];
			id_q   <= in_data[64:60];
			ra_q   <= in_data[65];
		end
	end

	// Slot counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.cnt_clr) begin
			cnt_q <= '0;
		end else if (cmd.cnt_inc) begin
			cnt_q <= cnt_q + SLOT_BITS'(1);
		end
	end

	// Descriptor write on a successful install.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			base_q[inst_idx]  <= addr_q[ADDR_BITS:0];
			len_q[inst_idx]   <= size_q;
			rdact_q[inst_idx] <= ra_q;
		end
	end

	// Reference counts wrap within their width.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MAX_SEGMENTS; i++) begin
				refc_q[i] <= '0;
			end
		end else if (cmd.commit) begin
			refc_q[inst_idx] <= refc_q[inst_idx] + REFC_W'(slot_count);
		end
	end

	// Pending result.
	always_ff @(posedge clk) begin
		case (cmd.res) inside
			RES_MISALIGN, RES_NOSPACE, RES_OVERLAP: begin
				pend_stat_q <= (cmd.res == RES_MISALIGN) ? STAT_MISALIGN :
					(cmd.res == RES_NOSPACE) ? STAT_NOSPACE : STAT_OVERLAP;
				pend_hit_q  <= '0;
				pend_off_q  <= '0;
				pend_blk_q  <= 1'b0;
			end
			RES_INSTALLED: begin
				pend_stat_q <= STAT_OK;
				pend_hit_q  <= id_q;
				pend_off_q  <= '0;
				pend_blk_q  <= 1'b0;
			end
			RES_FAULT: begin
				pend_stat_q <= STAT_FAULT;
				pend_hit_q  <= '0;
				pend_off_q  <= '0;
				pend_blk_q  <= 1'b1;
			end
			RES_ACCESS: begin
				pend_stat_q <= acc_fault ? STAT_FAULT : STAT_OK;
				pend_hit_q  <= acc_fault ? '0 : rd_q;
				pend_off_q  <= acc_fault ? '0 : acc_off;
				pend_blk_q  <= acc_fault ? 1'b1 : rdact_q[hit_idx];
			end
			RES_PEEK: begin
				pend_stat_q <= STAT_OK;
				pend_hit_q  <= rd_q;
				pend_off_q  <= '0;
				pend_blk_q  <= 1'b0;
			end
			RES_ZERO: begin
				pend_stat_q <= STAT_OK;
				pend_hit_q  <= '0;
				pend_off_q  <= '0;
				pend_blk_q  <= 1'b0;
			end
			default: begin
				pend_stat_q <= pend_stat_q;
			end
		endcase
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.push) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.push) begin
			out_data_q <= {7'b0, pend_blk_q, pend_off_q, pend_hit_q, pend_stat_q};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

### rtl/segment_map_address_decoder.sv
// A lookup or a peek reads the slot map in decode and then builds its result; an unused code,
// an access past the space, an install rejected on its checks or one of zero size goes from
// decode straight to the result. An install reads and then checks each of its N slots in the
// scan and then writes each in the fill, through the single port of the slot map. A new beat
// is taken only once the result has entered the output register, so one item is handled at a
// time. After reset the slot map is cleared with s_axis_tready low.
`default_nettype none

module segment_map_address_decoder (
	input  wire                              clk,
	input  wire                              arst_n,
	input  wire                              s_axis_tvalid,
	output logic                             s_axis_tready,
	// address[31:0], seg_size[56:32], access_size[59:57], segment_id[64:60], read_action[65]
	input  wire [smad_pkg::IN_DW-1:0]        s_axis_tdata,
	// func[1:0]
	input  wire [smad_pkg::FUNC_W-1:0]       s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  wire                              m_axis_tready,
	// status[2:0], hit_segment[7:3], offset[31:8], inspect_blocked[32]
	output logic [smad_pkg::OUT_DW-1:0]      m_axis_tdata
);
	import smad_pkg::*;

	smad_cmd_t  cmd;
	smad_stat_t stat;

	smad_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	smad_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (s_axis_tdata),
		.in_func   (s_axis_tuser),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata),
		.stat      (stat)
	);

endmodule

`default_nettype wire

### rtl/smad_checker.sv
`default_nettype none

module smad_checker (
	input wire                         clk,
	input wire                         arst_n,
	input wire                         s_axis_tvalid,
	input wire                         s_axis_tready,
	input wire                         m_axis_tvalid,
	input wire                         m_axis_tready,
	input wire [smad_pkg::OUT_DW-1:0]  m_axis_tdata
);
	import smad_pkg::*;

	// A held result beat stays unchanged.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// One item at a time: no beat is taken in the cycle after one was taken.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken while an item is in progress");

	// A fault names no segment, has no offset and blocks inspection.
	a_fault_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[2:0] == STAT_FAULT)
		|-> (m_axis_tdata[31:3] == '0) && m_axis_tdata[32])
		else $error("fault result with stray fields");

	// Any rejected install names no segment and does not block.
	a_reject_fields: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && ((m_axis_tdata[2:0] == STAT_MISALIGN)
		|| (m_axis_tdata[2:0] == STAT_OVERLAP) || (m_axis_tdata[2:0] == STAT_NOSPACE))
		|-> (m_axis_tdata[32:3] == '0))
		else $error("rejected install with stray fields");

endmodule

bind segment_map_address_decoder smad_checker u_smad_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
